// ===== design/rsi_pkg.sv =====
`default_nettype none
package rsi_pkg;

  // Field widths
  localparam int CW       = 24;           // coordinate width, signed
  localparam int DIRW     = 16;           // direction width, signed Q2.14
  localparam int DIR_FRAC = 14;
  localparam int REACHW   = 16;
  localparam logic [REACHW-1:0] REACH_RESET = 16'd1000;

  // Internal widths
  localparam int EW  = CW + 1;            // coordinate differences
  localparam int PDW = DIRW + EW;         // direction times difference
  localparam int CPW = PDW + 1;           // direction cross products
  localparam int AW  = CPW + REACHW + 1;  // A and B after scaling by reach
  localparam int PXW = 2 * EW;            // difference times difference
  localparam int XW  = PXW + 1;           // X cross product
  localparam int CMPW = AW + 16;          // ray range compare width

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_PARALLEL  = 2'd2,
    ST_NONE      = 2'd3
  } rsi_status_t;

  typedef struct packed {
    logic signed [CW-1:0]   ray_origin_x;
    logic signed [CW-1:0]   ray_origin_y;
    logic signed [DIRW-1:0] ray_dir_x;
    logic signed [DIRW-1:0] ray_dir_y;
    logic signed [CW-1:0]   seg_start_x;
    logic signed [CW-1:0]   seg_start_y;
    logic signed [CW-1:0]   seg_end_x;
    logic signed [CW-1:0]   seg_end_y;
  } rsi_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
  } rsi_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    rsi_status_t          status;
    logic [AW-1:0]        a_mag;
    logic [AW-1:0]        b_val;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ey;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } rsi_entry_t;

  // One stage of the crossing point divider
  typedef struct packed {
    rsi_status_t          status;
    logic [AW-1:0]        a_mag;
    logic [AW-1:0]        b_val;
    logic [CW-1:0]        mx;
    logic [CW-1:0]        my;
    logic                 nx;
    logic                 ny;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic [AW-1:0]        rx;
    logic [AW-1:0]        ry;
    logic [CW-1:0]        qx;
    logic [CW-1:0]        qy;
  } rsi_div_t;

  typedef struct packed {
    logic [AW-1:0] r;
    logic [CW-1:0] q;
  } rsi_step_t;

endpackage
`default_nettype wire

// ===== design/rsi_front.sv =====
`default_nettype none
module rsi_front import rsi_pkg::*; #(
  parameter int COORD_FRACTION_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_take,
  input  wire rsi_in_t           in_item,
  input  wire logic [REACHW-1:0] reach,
  output logic                   push,
  output rsi_entry_t             push_entry
);

  localparam int G  = DIR_FRAC - COORD_FRACTION_BITS;
  localparam int GP = (G > 0) ? G : 0;
  localparam int GN = (G < 0) ? -G : 0;

  logic [6:1] v_r;

  // stage 1: differences
  logic signed [EW-1:0]   ex1_r, ey1_r, ax1_r, ay1_r;
  logic signed [DIRW-1:0] dx1_r, dy1_r;
  logic signed [CW-1:0]   sx1_r, sy1_r;
  // stage 2: products
  logic signed [PDW-1:0]  p_dxey_r, p_dyex_r, p_axdy_r, p_aydx_r;
  logic signed [PXW-1:0]  p_axey_r, p_ayex_r;
  logic signed [EW-1:0]   ex2_r, ey2_r;
  logic signed [CW-1:0]   sx2_r, sy2_r;
  // stage 3: cross products before reach
  logic signed [CPW-1:0]  ca3_r, cb3_r;
  logic signed [XW-1:0]   x3_r, x4_r;
  logic signed [EW-1:0]   ex3_r, ey3_r, ex4_r, ey4_r, ex5_r, ey5_r;
  logic signed [CW-1:0]   sx3_r, sy3_r, sx4_r, sy4_r, sx5_r, sy5_r;
  // stage 4: scaled by reach
  logic signed [AW-1:0]   a4_r, b4_r;
  // stage 5: sign normalised
  logic [AW-1:0]          a5_r;
  logic signed [AW-1:0]   b5_r;
  logic [XW-1:0]          xm5_r;
  logic                   a_zero5_r, b_zero5_r;

  rsi_entry_t             entry_nxt, entry_r;
  logic [CMPW-1:0]        x_cmp, a_cmp;
  logic                   t_ok, u_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:1], in_take};
    end
  end

  always_ff @(posedge clk) begin
    ex1_r <= EW'(in_item.seg_end_x) - EW'(in_item.seg_start_x);
    ey1_r <= EW'(in_item.seg_end_y) - EW'(in_item.seg_start_y);
    ax1_r <= EW'(in_item.seg_start_x) - EW'(in_item.ray_origin_x);
    ay1_r <= EW'(in_item.seg_start_y) - EW'(in_item.ray_origin_y);
    dx1_r <= in_item.ray_dir_x;
    dy1_r <= in_item.ray_dir_y;
    sx1_r <= in_item.seg_start_x;
    sy1_r <= in_item.seg_start_y;

    p_dxey_r <= PDW'(dx1_r) * PDW'(ey1_r);
    p_dyex_r <= PDW'(dy1_r) * PDW'(ex1_r);
    p_axdy_r <= PDW'(ax1_r) * PDW'(dy1_r);
    p_aydx_r <= PDW'(ay1_r) * PDW'(dx1_r);
    p_axey_r <= PXW'(ax1_r) * PXW'(ey1_r);
    p_ayex_r <= PXW'(ay1_r) * PXW'(ex1_r);
    ex2_r <= ex1_r;  ey2_r <= ey1_r;
    sx2_r <= sx1_r;  sy2_r <= sy1_r;

    ca3_r <= CPW'(p_dxey_r) - CPW'(p_dyex_r);
    cb3_r <= CPW'(p_axdy_r) - CPW'(p_aydx_r);
    x3_r  <= XW'(p_axey_r) - XW'(p_ayex_r);
    ex3_r <= ex2_r;  ey3_r <= ey2_r;
    sx3_r <= sx2_r;  sy3_r <= sy2_r;

    // A = reach * (d x e), B = reach * (a x d)
    a4_r  <= AW'(ca3_r) * AW'(signed'({1'b0, reach}));
    b4_r  <= AW'(cb3_r) * AW'(signed'({1'b0, reach}));
    x4_r  <= x3_r;
    ex4_r <= ex3_r;  ey4_r <= ey3_r;
    sx4_r <= sx3_r;  sy4_r <= sy3_r;

    // flip A and B so that A is positive; |X| is the same either way
    a5_r      <= a4_r[AW-1] ? AW'(-a4_r) : AW'(a4_r);
    b5_r      <= a4_r[AW-1] ? -b4_r : b4_r;
    xm5_r     <= x4_r[XW-1] ? XW'(-x4_r) : XW'(x4_r);
    a_zero5_r <= (a4_r == '0);
    b_zero5_r <= (b4_r == '0);
    ex5_r <= ex4_r;  ey5_r <= ey4_r;
    sx5_r <= sx4_r;  sy5_r <= sy4_r;
  end

  // ray range: |X| * 2^|g| against A
  always_comb begin
    x_cmp = CMPW'(xm5_r) << GN;
    a_cmp = CMPW'(a5_r) >> GP;
    t_ok  = (x_cmp <= a_cmp);
    u_ok  = !b5_r[AW-1] && (AW'(b5_r) <= a5_r);

    entry_nxt.a_mag = a5_r;
    entry_nxt.b_val = AW'(b5_r);
    entry_nxt.ex    = ex5_r;
    entry_nxt.ey    = ey5_r;
    entry_nxt.sx    = sx5_r;
    entry_nxt.sy    = sy5_r;
    if (a_zero5_r) begin
      entry_nxt.status = b_zero5_r ? ST_COLLINEAR : ST_PARALLEL;
    end else if (t_ok && u_ok) begin
      entry_nxt.status = ST_HIT;
    end else begin
      entry_nxt.status = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign push       = v_r[6];
  assign push_entry = entry_r;

endmodule
`default_nettype wire

// ===== design/rsi_queue.sv =====
`default_nettype none
module rsi_queue import rsi_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire rsi_entry_t push_entry,
  input  wire logic       pop,
  output logic            head_valid,
  output rsi_entry_t      head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  rsi_entry_t      mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  // no overflow guard: the top level holds the input off by credit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rd_ptr_r];

endmodule
`default_nettype wire

// ===== design/rsi_back.sv =====
`default_nettype none
module rsi_back import rsi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire rsi_entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rsi_out_t        out_item
);

  function automatic rsi_step_t div_step(input logic [AW-1:0] r, input logic [CW-1:0] q,
                                         input logic bitv, input logic [AW-1:0] a,
                                         input logic [AW-1:0] b);
    logic [AW+1:0] t;
    logic [AW+1:0] a1;
    logic [AW+1:0] a2;
    rsi_step_t     s;
    t  = ((AW+2)'(r) << 1) + (bitv ? (AW+2)'(b) : '0);
    a1 = (AW+2)'(a);
    a2 = a1 << 1;
    if (t >= a2) begin
      s.r = AW'(t - a2);
      s.q = (q << 1) + CW'(2);
    end else if (t >= a1) begin
      s.r = AW'(t - a1);
      s.q = (q << 1) + CW'(1);
    end else begin
      s.r = AW'(t);
      s.q = q << 1;
    end
    return s;
  endfunction

  function automatic logic signed [CW-1:0] finish(input logic signed [CW-1:0] s,
                                                  input logic [CW-1:0] q, input logic [AW-1:0] r,
                                                  input logic [AW-1:0] a, input logic neg);
    logic [CW:0]          qr;
    logic signed [CW+1:0] sum;
    logic signed [CW+1:0] hi;
    logic signed [CW+1:0] lo;
    qr  = (CW+1)'(q) + (((AW+1)'(r) << 1) >= (AW+1)'(a) ? (CW+1)'(1) : '0);
    sum = (CW+2)'(s) + (neg ? -(CW+2)'(qr) : (CW+2)'(qr));
    hi  = (CW+2)'({1'b0, {(CW-1){1'b1}}});
    lo  = -hi - (CW+2)'(1);
    if (sum > hi) begin
      return hi[CW-1:0];
    end else if (sum < lo) begin
      return lo[CW-1:0];
    end
    return sum[CW-1:0];
  endfunction

  logic       en;
  logic [CW:0] v_r;
  rsi_div_t   st_r [CW+1];
  rsi_div_t   st0_nxt;
  logic       out_valid_r;
  rsi_out_t   out_item_r, out_item_nxt;

  assign en  = !out_valid_r || !out_stall;
  assign pop = head_valid && en;

  always_comb begin
    st0_nxt.status = head_entry.status;
    st0_nxt.a_mag  = head_entry.a_mag;
    st0_nxt.b_val  = head_entry.b_val;
    st0_nxt.mx     = CW'(head_entry.ex[EW-1] ? -head_entry.ex : head_entry.ex);
    st0_nxt.my     = CW'(head_entry.ey[EW-1] ? -head_entry.ey : head_entry.ey);
    st0_nxt.nx     = head_entry.ex[EW-1];
    st0_nxt.ny     = head_entry.ey[EW-1];
    st0_nxt.sx     = head_entry.sx;
    st0_nxt.sy     = head_entry.sy;
    st0_nxt.rx     = '0;
    st0_nxt.ry     = '0;
    st0_nxt.qx     = '0;
    st0_nxt.qy     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[CW-1:0], pop};
      out_valid_r <= v_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_nxt;
    end
  end

  // one bit of |e| per stage, most significant first
  for (genvar i = 1; i <= CW; i++) begin : g_div
    rsi_div_t  st_nxt;
    rsi_step_t sx_step, sy_step;
    always_comb begin
      sx_step = div_step(st_r[i-1].rx, st_r[i-1].qx, st_r[i-1].mx[CW-i],
                         st_r[i-1].a_mag, st_r[i-1].b_val);
      sy_step = div_step(st_r[i-1].ry, st_r[i-1].qy, st_r[i-1].my[CW-i],
                         st_r[i-1].a_mag, st_r[i-1].b_val);
      st_nxt    = st_r[i-1];
      st_nxt.rx = sx_step.r;
      st_nxt.qx = sx_step.q;
      st_nxt.ry = sy_step.r;
      st_nxt.qy = sy_step.q;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= st_nxt;
      end
    end
  end

  always_comb begin
    out_item_nxt.status = st_r[CW].status;
    out_item_nxt.hit_x  = '0;
    out_item_nxt.hit_y  = '0;
    if (st_r[CW].status == ST_HIT) begin
      out_item_nxt.hit_x = finish(st_r[CW].sx, st_r[CW].qx, st_r[CW].rx,
                                  st_r[CW].a_mag, st_r[CW].nx);
      out_item_nxt.hit_y = finish(st_r[CW].sy, st_r[CW].qy, st_r[CW].ry,
                                  st_r[CW].a_mag, st_r[CW].ny);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== design/ray_segment_intersection.sv =====
`default_nettype none
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_item (rsi_in_t)  | in
// result   | out_valid, out_stall, out_item          | out
// config   | cfg_wr_en, cfg_wr_data (reach)          | in
//
// One item per cycle sustained while neither out_stall nor in_stall holds the
// flow. Items pass through the cross-product front, then the queue, then the
// restoring divider and output register of the back. Reset is synchronous;
// it empties every stage and sets reach to 1000. out_stall freezes only the
// back; the front keeps taking items until the queue credits run out, then
// raises in_stall.
module ray_segment_intersection import rsi_pkg::*; #(
  parameter int COORD_FRACTION_BITS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [REACHW-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rsi_in_t           in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rsi_out_t               out_item
);

  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [REACHW-1:0] reach_r;
  logic [CNTW-1:0]   credit_r;   // items in the front or the queue
  logic              in_take;
  logic              push, pop, head_valid;
  rsi_entry_t        push_entry, head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= REACH_RESET;
    end else if (cfg_wr_en) begin
      reach_r <= cfg_wr_data;
    end
  end

  // every item in flight in the front is sure of a queue slot
  assign in_stall = (credit_r == CNTW'(QUEUE_DEPTH));
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (in_take && !pop) begin
      credit_r <= credit_r + 1'b1;
    end else if (pop && !in_take) begin
      credit_r <= credit_r - 1'b1;
    end
  end

  rsi_front #(
    .COORD_FRACTION_BITS(COORD_FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_item    (in_item),
    .reach      (reach_r),
    .push       (push),
    .push_entry (push_entry)
  );

  rsi_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
